// ===== rtl/srts_pkg.sv =====
// shared types and constants for the sorted record table search block
package srts_pkg;

    localparam int KEY_W = 16;
    localparam int SAL_W = 20;
    localparam int POS_W = 5;
    localparam int STATUS_W = 2;
    localparam int OP_W = 3;
    localparam int MAX_RESULTS = 32;
    localparam int RCNT_W = 6;
    localparam logic [SAL_W-1:0] THRESHOLD_RESET = 20'd1000;

    localparam logic [OP_W-1:0] OP_LOAD = 3'd0;
    localparam logic [OP_W-1:0] OP_SORT = 3'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
    localparam logic [OP_W-1:0] OP_ABOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_BELOW = 3'd4;
    localparam logic [OP_W-1:0] OP_EQUAL = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [SAL_W-1:0] sal;
    } rec_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT,
        S_SEARCH,
        S_LIST,
        S_ALIGN
    } state_t;

endpackage

// ===== rtl/srts_cell.sv =====
// one table cell: holds a record, shifts toward the head, compare-swaps with its upper neighbor
module srts_cell #(
    parameter int IDX = 0,
    parameter int CW = 6
) (
    input  logic          aclk,
    input  logic          load_en,
    input  srts_pkg::rec_t load_rec,
    input  logic          shift_en,
    input  srts_pkg::rec_t shift_rec,
    input  logic          sort_en,
    input  logic          phase,
    input  logic [CW-1:0] count,
    input  srts_pkg::rec_t upper_rec,
    input  srts_pkg::rec_t lower_rec,
    input  logic          swap_from_below,
    output srts_pkg::rec_t rec,
    output logic          swap_up
);
    import srts_pkg::*;

    rec_t rec_reg, rec_next;
    logic active_lo;

    assign active_lo = sort_en && ((IDX % 2) == int'(phase)) &&
                       ({1'b0, count} > (CW+1)'(IDX + 1));
    // strict compare keeps equal keys in stored order
    assign swap_up = active_lo && (rec_reg.key > upper_rec.key);

    always_comb begin
        priority if (load_en) begin
            rec_next = load_rec;
        end else if (shift_en) begin
            rec_next = shift_rec;
        end else if (swap_up) begin
            rec_next = upper_rec;
        end else if (swap_from_below) begin
            rec_next = lower_rec;
        end else begin
            rec_next = rec_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule

// ===== rtl/sorted_record_table_search.sv =====
// sorted record table search: top level with the cell row and the command sequencer
//
// input channel s_*: one command per transaction, op in s_tuser, key and salary in s_tdata.
// result channel m_*: status in m_tuser, position/key/salary in m_tdata, m_tlast marks the
// final result of a command.
// cfg_we/cfg_wdata write salary_threshold, used by the three listing commands.
// records sit in a row of DEPTH cells. load writes the next free cell and answers with its
// position, or answers full when all cells hold records. sort runs DEPTH odd-even
// compare-swap rounds across the cells. search and listing rotate the row one cell per
// cycle past the head cell, then rotate back to alignment; a listing pauses while a
// waiting result is held by the receiver, and a search waits at each probed cell for the
// result register. one command is worked at a time and s_tready is high only when the
// sequencer is idle and the result register can take data.
// a stall on m_tready holds the result register and pauses the row rotation of a listing.
// reset clears the record count and the result valid flag and sets the threshold to 1000;
// cell contents are undefined until loaded.
module sorted_record_table_search #(
    parameter int DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // key_in[15:0], salary_in[35:16], zero fill
    input  logic [2:0]  s_tuser,   // op[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // position[4:0], key_out[20:5], salary_out[40:21], zero fill
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata
);
    import srts_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [RCNT_W-1:0] rcnt_reg, rcnt_next;
    logic [CW-1:0] round_reg, round_next;
    logic [OP_W-1:0] op_reg, op_next;
    logic [KEY_W-1:0] skey_reg, skey_next;
    logic [SAL_W-1:0] thr_reg;
    logic pend_valid_reg, pend_valid_next;
    rec_t pend_rec_reg, pend_rec_next;
    logic [POS_W-1:0] pend_pos_reg, pend_pos_next;

    logic m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [POS_W-1:0] m_pos_reg, m_pos_next;
    rec_t m_rec_reg, m_rec_next;
    logic m_last_reg, m_last_next;

    logic out_free, accept, shift_en, sort_en, hit;
    logic [OP_W-1:0] in_op;
    rec_t in_rec, head;
    logic [CW-1:0] mid, lo_n, hi_n;

    rec_t rec_arr [DEPTH];
    logic swap_arr [DEPTH];

    assign in_op = s_tuser;
    assign in_rec.key = s_tdata[15:0];
    assign in_rec.sal = s_tdata[35:16];
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept = s_tvalid && s_tready;
    assign head = rec_arr[0];
    assign mid = CW'(({1'b0, lo_reg} + {1'b0, hi_reg} - (CW+1)'(1)) >> 1);
    assign sort_en = (state_reg == S_SORT);

    always_comb begin
        unique case (op_reg)
            OP_ABOVE: hit = head.sal > thr_reg;
            OP_BELOW: hit = head.sal < thr_reg;
            default:  hit = head.sal == thr_reg;
        endcase
    end

    // cell row
    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        srts_cell #(.IDX(j), .CW(CW)) u_cell (
            .aclk            (aclk),
            .load_en         (accept && (in_op == OP_LOAD) && (count_reg == CW'(j))),
            .load_rec        (in_rec),
            .shift_en        (shift_en),
            .shift_rec       (rec_arr[(j + 1) % DEPTH]),
            .sort_en         (sort_en),
            .phase           (round_reg[0]),
            .count           (count_reg),
            .upper_rec       (rec_arr[(j + 1) % DEPTH]),
            .lower_rec       (rec_arr[(j + DEPTH - 1) % DEPTH]),
            .swap_from_below ((j == 0) ? 1'b0 : swap_arr[(j + DEPTH - 1) % DEPTH]),
            .rec             (rec_arr[j]),
            .swap_up         (swap_arr[j])
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    priority if (in_op == OP_SORT) begin
                        state_next = S_SORT;
                    end else if (in_op == OP_SEARCH) begin
                        state_next = (count_reg == '0) ? S_IDLE : S_SEARCH;
                    end else if (in_op == OP_ABOVE || in_op == OP_BELOW ||
                                 in_op == OP_EQUAL) begin
                        state_next = S_LIST;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SORT: begin
                if (round_reg == CW'(DEPTH - 1)) state_next = S_IDLE;
            end
            S_SEARCH: begin
                if ({1'b0, ptr_reg} == (PW+1)'(mid) && out_free &&
                    (skey_reg == head.key || lo_n >= hi_n)) state_next = S_ALIGN;
            end
            S_LIST: begin
                if ((idx_reg == count_reg || rcnt_reg == RCNT_W'(MAX_RESULTS)) && out_free)
                    state_next = S_ALIGN;
            end
            S_ALIGN: begin
                if (ptr_reg == '0) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (skey_reg < head.key) begin
            lo_n = lo_reg;
            hi_n = mid;
        end else begin
            lo_n = mid + CW'(1);
            hi_n = hi_reg;
        end
    end

    // datapath and outputs
    always_comb begin
        count_next = count_reg;
        ptr_next = ptr_reg;
        idx_next = idx_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        rcnt_next = rcnt_reg;
        round_next = round_reg;
        op_next = op_reg;
        skey_next = skey_reg;
        pend_valid_next = pend_valid_reg;
        pend_rec_next = pend_rec_reg;
        pend_pos_next = pend_pos_reg;
        shift_en = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_pos_next = m_pos_reg;
        m_rec_next = m_rec_reg;
        m_last_next = m_last_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next = in_op;
                    skey_next = in_rec.key;
                    lo_next = '0;
                    hi_next = count_reg;
                    idx_next = '0;
                    rcnt_next = '0;
                    round_next = '0;
                    pend_valid_next = 1'b0;
                    m_last_next = 1'b1;
                    m_pos_next = '0;
                    m_rec_next = '0;
                    priority if (in_op == OP_LOAD) begin
                        m_valid_next = 1'b1;
                        if ({1'b0, count_reg} < (CW+1)'(DEPTH)) begin
                            m_status_next = ST_OK;
                            m_pos_next = POS_W'(count_reg);
                            m_rec_next = in_rec;
                            count_next = count_reg + CW'(1);
                        end else begin
                            m_status_next = ST_FULL;
                        end
                    end else if (in_op == OP_SORT) begin
                        m_valid_next = 1'b1;
                        m_status_next = ST_OK;
                    end else if (in_op == OP_SEARCH) begin
                        if (count_reg == '0) begin
                            m_valid_next = 1'b1;
                            m_status_next = ST_NOT_FOUND;
                        end
                    end else begin
                    end
                end
            end
            S_SORT: begin
                round_next = round_reg + CW'(1);
            end
            S_SEARCH: begin
                if ({1'b0, ptr_reg} == (PW+1)'(mid)) begin
                    if (out_free) begin
                        if (skey_reg == head.key) begin
                            m_valid_next = 1'b1;
                            m_status_next = ST_OK;
                            m_pos_next = POS_W'(ptr_reg);
                            m_rec_next = head;
                            m_last_next = 1'b1;
                        end else if (lo_n >= hi_n) begin
                            m_valid_next = 1'b1;
                            m_status_next = ST_NOT_FOUND;
                            m_pos_next = '0;
                            m_rec_next = '0;
                            m_last_next = 1'b1;
                        end else begin
                            lo_next = lo_n;
                            hi_next = hi_n;
                        end
                    end
                end else begin
                    shift_en = 1'b1;
                    ptr_next = (ptr_reg == PW'(DEPTH - 1)) ? '0 : ptr_reg + PW'(1);
                end
            end
            S_LIST: begin
                if (idx_reg == count_reg || rcnt_reg == RCNT_W'(MAX_RESULTS)) begin
                    // close out with the held result or a no-match result
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_last_next = 1'b1;
                        if (pend_valid_reg) begin
                            m_status_next = ST_OK;
                            m_pos_next = pend_pos_reg;
                            m_rec_next = pend_rec_reg;
                        end else begin
                            m_status_next = ST_NO_MATCH;
                            m_pos_next = '0;
                            m_rec_next = '0;
                        end
                    end
                end else if (!(hit && pend_valid_reg && !out_free)) begin
                    if (hit) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_status_next = ST_OK;
                            m_pos_next = pend_pos_reg;
                            m_rec_next = pend_rec_reg;
                            m_last_next = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_rec_next = head;
                        pend_pos_next = POS_W'(ptr_reg);
                        rcnt_next = rcnt_reg + RCNT_W'(1);
                    end
                    shift_en = 1'b1;
                    ptr_next = (ptr_reg == PW'(DEPTH - 1)) ? '0 : ptr_reg + PW'(1);
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_ALIGN: begin
                if (ptr_reg != '0) begin
                    shift_en = 1'b1;
                    ptr_next = (ptr_reg == PW'(DEPTH - 1)) ? '0 : ptr_reg + PW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg <= '0;
            m_valid_reg <= 1'b0;
            thr_reg <= THRESHOLD_RESET;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg <= ptr_next;
            m_valid_reg <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_we) thr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        rcnt_reg <= rcnt_next;
        round_reg <= round_next;
        op_reg <= op_next;
        skey_reg <= skey_next;
        pend_rec_reg <= pend_rec_next;
        pend_pos_reg <= pend_pos_next;
        m_status_reg <= m_status_next;
        m_pos_reg <= m_pos_next;
        m_rec_reg <= m_rec_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser = m_status_reg;
    assign m_tlast = m_last_reg;
    assign m_tdata = {7'd0, m_rec_reg.sal, m_rec_reg.key, m_pos_reg};

endmodule

// ===== rtl/srts_checker.sv =====
// port-level checker for the sorted record table search block, with its bind
module srts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import srts_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_fail_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tlast && m_tdata == 48'd0)
        else $error("failure result not final or not zero");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && m_tvalid && !m_tready |-> 1'b0)
        else $error("command taken while result register blocked");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind sorted_record_table_search srts_checker u_srts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== sim/sorted_record_table_search_tb.sv =====
// testbench for the sorted record table search block: table-driven directed part, then random commands
`timescale 1ns / 1ps

module sorted_record_table_search_tb;
    import srts_pkg::*;

    localparam int DEPTH = 32;
    localparam int LIST_LIMIT = 32;
    localparam int RANDOM_ITEMS = 82;
    localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [KEY_W-1:0]    key;
        logic [SAL_W-1:0]    sal;
        logic                last;
    } answer_t;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [SAL_W-1:0] sal;
        bit               typed;
        answer_t          ans;
    } cmd_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [19:0] cfg_wdata = '0;

    sorted_record_table_search #(.DEPTH(DEPTH)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [KEY_W-1:0] tbl_key [DEPTH];
    logic [SAL_W-1:0] tbl_sal [DEPTH];
    int               tbl_count;
    logic [SAL_W-1:0] threshold;

    answer_t pending_answers[$];
    int      errors = 0;
    bit      rx_enable = 1'b0;

    function automatic answer_t mk(logic [1:0] st, logic [4:0] p, logic [15:0] k,
                                   logic [19:0] s, logic l);
        answer_t a;
        a.status = st; a.position = p; a.key = k; a.sal = s; a.last = l;
        return a;
    endfunction

    function automatic bit salary_selected(logic [OP_W-1:0] op, logic [SAL_W-1:0] s);
        if (op == OP_ABOVE) return s > threshold;
        if (op == OP_BELOW) return s < threshold;
        return s == threshold;
    endfunction

    // updates the table copy and queues every answer the command causes
    task automatic predict_command(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                   logic [SAL_W-1:0] s);
        int lo, hi, mid, cnt, j;
        logic [KEY_W-1:0] tk;
        logic [SAL_W-1:0] ts;
        answer_t a;
        case (op)
            OP_LOAD: begin
                if (tbl_count < DEPTH) begin
                    tbl_key[tbl_count] = k;
                    tbl_sal[tbl_count] = s;
                    pending_answers.push_back(mk(ST_OK, tbl_count[4:0], k, s, 1'b1));
                    tbl_count++;
                end else begin
                    pending_answers.push_back(mk(ST_FULL, '0, '0, '0, 1'b1));
                end
            end
            OP_SORT: begin
                for (int i = 1; i < tbl_count; i++) begin
                    tk = tbl_key[i]; ts = tbl_sal[i]; j = i;
                    while (j > 0 && tbl_key[j-1] > tk) begin
                        tbl_key[j] = tbl_key[j-1]; tbl_sal[j] = tbl_sal[j-1]; j--;
                    end
                    tbl_key[j] = tk; tbl_sal[j] = ts;
                end
                pending_answers.push_back(mk(ST_OK, '0, '0, '0, 1'b1));
            end
            OP_SEARCH: begin
                lo = 0; hi = tbl_count;
                a = mk(ST_NOT_FOUND, '0, '0, '0, 1'b1);
                while (lo < hi) begin
                    mid = (lo + hi - 1) / 2;
                    if (k == tbl_key[mid]) begin
                        a = mk(ST_OK, mid[4:0], tbl_key[mid], tbl_sal[mid], 1'b1);
                        break;
                    end
                    if (k < tbl_key[mid]) hi = mid;
                    else lo = mid + 1;
                end
                pending_answers.push_back(a);
            end
            OP_ABOVE, OP_BELOW, OP_EQUAL: begin
                cnt = 0;
                for (int i = 0; i < tbl_count && cnt < LIST_LIMIT; i++) begin
                    if (salary_selected(op, tbl_sal[i])) begin
                        pending_answers.push_back(mk(ST_OK, i[4:0], tbl_key[i], tbl_sal[i], 1'b0));
                        cnt++;
                    end
                end
                if (cnt == 0) pending_answers.push_back(mk(ST_NO_MATCH, '0, '0, '0, 1'b1));
                else pending_answers[$].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic idle_cycles(int n);
        repeat (n) @(posedge aclk);
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // leaves s_tvalid high after the accepting edge; the caller drops it when a gap follows
    task automatic send_command(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                logic [SAL_W-1:0] s);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'b0, s, k};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_command(op, k, s);
    endtask

    task automatic drain_and_set_threshold(logic [SAL_W-1:0] v);
        while (pending_answers.size() != 0) @(posedge aclk);
        // ignored op codes may leave no answer to wait for, so let the row settle
        idle_cycles(4 * DEPTH);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        threshold = v;
    endtask

    // result checker with random back-pressure
    always @(posedge aclk) begin
        answer_t got, want;
        if (m_tvalid && m_tready) begin
            got = mk(m_tuser, m_tdata[4:0], m_tdata[20:5], m_tdata[40:21], m_tlast);
            if (pending_answers.size() == 0) begin
                $error("unexpected result transaction: %p", got);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                if (got.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, got.status); errors++;
                end
                if (got.position !== want.position) begin
                    $error("position expected %0d actual %0d", want.position, got.position);
                    errors++;
                end
                if (got.key !== want.key) begin
                    $error("key_out expected %0h actual %0h", want.key, got.key); errors++;
                end
                if (got.sal !== want.sal) begin
                    $error("salary_out expected %0h actual %0h", want.sal, got.sal); errors++;
                end
                if (got.last !== want.last) begin
                    $error("last expected %0d actual %0d", want.last, got.last); errors++;
                end
            end
        end
    end

    int stall_left = 0;
    always @(posedge aclk) begin
        if (!rx_enable) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left <= random_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        #20000000;
        $display("sorted_record_table_search_tb: done, errors");
        $finish;
    end

    cmd_row_t rows[$];

    function automatic cmd_row_t row(logic [2:0] op, logic [15:0] k, logic [19:0] s,
                                     bit typed, answer_t a);
        cmd_row_t r;
        r.op = op; r.key = k; r.sal = s; r.typed = typed; r.ans = a;
        return r;
    endfunction

    initial begin
        answer_t none;
        cmd_row_t cr;
        logic [OP_W-1:0] op;
        logic [KEY_W-1:0] k;
        logic [SAL_W-1:0] s;
        int r, gap;
        none = '0;
        tbl_count = 0;
        threshold = THRESHOLD_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        rx_enable <= 1'b1;
        @(posedge aclk);

        // empty table answers, then extremes of keys and salaries
        rows.push_back(row(OP_SEARCH, 16'h0000, '0, 1'b1,
                           mk(ST_NOT_FOUND, '0, '0, '0, 1'b1)));
        rows.push_back(row(OP_ABOVE, '0, '0, 1'b1, mk(ST_NO_MATCH, '0, '0, '0, 1'b1)));
        rows.push_back(row(OP_SORT, '0, '0, 1'b1, mk(ST_OK, '0, '0, '0, 1'b1)));
        rows.push_back(row(OP_LOAD, 16'hFFFF, 20'hFFFFF, 1'b1,
                           mk(ST_OK, 5'd0, 16'hFFFF, 20'hFFFFF, 1'b1)));
        rows.push_back(row(OP_LOAD, 16'h0000, 20'h00000, 1'b1,
                           mk(ST_OK, 5'd1, '0, '0, 1'b1)));
        rows.push_back(row(OP_LOAD, 16'h1234, 20'd1000, 1'b1,
                           mk(ST_OK, 5'd2, 16'h1234, 20'd1000, 1'b1)));
        rows.push_back(row(OP_LOAD, 16'h1234, 20'd5, 1'b0, none));
        rows.push_back(row(OP_UNUSED_A, 16'hAAAA, 20'h55555, 1'b0, none));
        rows.push_back(row(OP_UNUSED_B, 16'h5555, 20'hAAAAA, 1'b0, none));
        rows.push_back(row(OP_EQUAL, '0, '0, 1'b0, none));
        rows.push_back(row(OP_ABOVE, '0, '0, 1'b0, none));
        rows.push_back(row(OP_BELOW, '0, '0, 1'b0, none));
        rows.push_back(row(OP_SEARCH, 16'h1234, '0, 1'b0, none));
        rows.push_back(row(OP_SORT, '0, '0, 1'b0, none));
        rows.push_back(row(OP_SEARCH, 16'hFFFF, '0, 1'b0, none));
        rows.push_back(row(OP_SEARCH, 16'h0000, '0, 1'b0, none));
        rows.push_back(row(OP_SEARCH, 16'h7777, '0, 1'b1,
                           mk(ST_NOT_FOUND, '0, '0, '0, 1'b1)));
        rows.push_back(row(OP_EQUAL, '0, '0, 1'b0, none));

        foreach (rows[i]) begin
            cr = rows[i];
            send_command(cr.op, cr.key, cr.sal);
            if (cr.typed) begin
                void'(pending_answers.pop_back());
                pending_answers.push_back(cr.ans);
            end
            gap = random_gap();
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                idle_cycles(gap);
            end
        end

        // random commands
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 30) drain_and_set_threshold(20'd500);
            if (n == 60) drain_and_set_threshold(20'hFFFFF);
            r = $urandom_range(0, 99);
            if (r < 50) op = OP_LOAD;
            else if (r < 56) op = OP_SORT;
            else if (r < 72) op = OP_SEARCH;
            else if (r < 80) op = OP_ABOVE;
            else if (r < 88) op = OP_BELOW;
            else if (r < 95) op = OP_EQUAL;
            else if (r < 97) op = OP_UNUSED_A;
            else op = OP_UNUSED_B;
            if (op == OP_SEARCH && tbl_count > 0 && $urandom_range(0, 2) != 0)
                k = tbl_key[$urandom_range(0, tbl_count - 1)];
            else if ($urandom_range(0, 15) == 0)
                k = 16'hFFFF;
            else
                k = KEY_W'($urandom_range(0, 63));
            if ($urandom_range(0, 3) == 0) s = threshold;
            else s = SAL_W'($urandom_range(0, 2000));
            send_command(op, k, s);
            gap = random_gap();
            if (gap > 0 || n == 29 || n == 59 || n == RANDOM_ITEMS - 1) begin
                s_tvalid <= 1'b0;
                idle_cycles(gap);
            end
        end

        while (pending_answers.size() != 0) @(posedge aclk);
        idle_cycles(4 * DEPTH);
        if (errors == 0) $display("sorted_record_table_search_tb: done, clean");
        else $display("sorted_record_table_search_tb: done, errors");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/srts_pkg.sv
rtl/srts_cell.sv
rtl/sorted_record_table_search.sv
rtl/srts_checker.sv
sim/sorted_record_table_search_tb.sv
